>>> design/u64da_pkg.sv
// ============================================================================
// u64da_pkg - shared types and helpers for the 64-bit decimal ASCII converter
// Holds the widths, the word carried down the cell chain and the one-bit
// shift-and-adjust step that every cell applies.
// ============================================================================
package u64da_pkg;

    localparam int BIN_W       = 64;
    localparam int DIGIT_COUNT = 20;
    localparam int BCD_W       = 4 * DIGIT_COUNT;
    localparam int CELL_COUNT  = BIN_W;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [3:0] ADJ_LIMIT  = 4'd5;
    localparam logic [3:0] ADJ_ADD    = 4'd3;

    // Word handed from cell to cell: unconsumed binary bits and BCD so far
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } word_t;

    // One double-dabble step: adjust each BCD digit, then shift in one bit
    function automatic word_t u64da_step(input word_t w);
        logic [BCD_W-1:0] adj;
        word_t            res;
        adj = w.bcd;
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (w.bcd[4*d +: 4] >= ADJ_LIMIT) begin
                adj[4*d +: 4] = w.bcd[4*d +: 4] + ADJ_ADD;
            end
        end
        res.bcd = {adj[BCD_W-2:0], w.bin[BIN_W-1]};
        res.bin = {w.bin[BIN_W-2:0], 1'b0};
        return res;
    endfunction

endpackage

>>> design/u64da_cell.sv
// ============================================================================
// u64da_cell - one stage of the conversion chain
// Takes a word from its upstream neighbor, applies one shift-and-adjust step
// and holds the result for its downstream neighbor. Bubbles collapse: the cell
// loads whenever it is empty or its content moves on.
// ============================================================================
module u64da_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  u64da_pkg::word_t   in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output u64da_pkg::word_t   out_word
);

    logic             valid_reg;
    logic             valid_next;
    u64da_pkg::word_t word_reg;
    u64da_pkg::word_t word_next;

    // Load when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                word_next = u64da_pkg::u64da_step(in_word);
            end
        end
    end

    // Hold control under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload carries no reset
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> design/uint64_to_decimal_ascii.sv
// ============================================================================
// uint64_to_decimal_ascii - unsigned 64-bit binary to 20 ASCII decimal digits
// A chain of 64 shift-and-adjust cells turns the binary value into packed BCD,
// one input bit per cell; the last cell's digits are mapped to ASCII.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_value[63:0]
//  m_      | out       | m_valid / m_ready  | m_chars_top, m_chars_mid,
//          |           |                    | m_chars_low
//
//  An item passes through the register of every cell in turn; one item enters per cycle while s_ready is high.
//  Every cell holds one item, so up to 64 items are in flight.
//  Reset clears only the valid bit of each cell; nothing else needs clearing.
//  A stall at m_ready fills the chain from the end; empty cells keep taking
//  items, so s_ready drops only once all 64 cells hold an item.
//
module uint64_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_chars_top,
    output logic [63:0] m_chars_mid,
    output logic [31:0] m_chars_low
);

    localparam int NCELL = u64da_pkg::CELL_COUNT;

    logic             stage_valid [0:NCELL];
    logic             stage_ready [0:NCELL];
    u64da_pkg::word_t stage_word  [0:NCELL];
    logic [u64da_pkg::BCD_W-1:0] bcd;
    logic [8*u64da_pkg::DIGIT_COUNT-1:0] chars;

    // Feed the chain head with the raw value and empty BCD
    assign stage_valid[0]    = s_valid;
    assign s_ready           = stage_ready[0];
    assign stage_word[0].bin = s_value;
    assign stage_word[0].bcd = '0;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        u64da_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[c]),
            .in_ready  (stage_ready[c]),
            .in_word   (stage_word[c]),
            .out_valid (stage_valid[c+1]),
            .out_ready (stage_ready[c+1]),
            .out_word  (stage_word[c+1])
        );
    end

    assign m_valid            = stage_valid[NCELL];
    assign stage_ready[NCELL] = m_ready;
    assign bcd                = stage_word[NCELL].bcd;

    // Map each BCD digit to its ASCII character; the most significant digit lands in the top byte
    always_comb begin
        for (int d = 0; d < u64da_pkg::DIGIT_COUNT; d++) begin
            chars[8*d +: 8] = u64da_pkg::ASCII_ZERO | {4'h0, bcd[4*d +: 4]};
        end
    end

    assign m_chars_top = chars[159:96];
    assign m_chars_mid = chars[95:32];
    assign m_chars_low = chars[31:0];

endmodule
